/* hdl/psg_pkg.sv */
// shared types, constants and the attenuation table of the tone and noise generator
package psg_pkg;

	// amplitude word width, Q1.(AMP_BITS-1)
	localparam int AMP_BITS = 16;

	// mix accumulator width: four signed amplitudes, never below the sample width
	localparam int SAMPLE_W = 18;
	localparam int SUM_W    = (AMP_BITS + 2 > SAMPLE_W) ? AMP_BITS + 2 : SAMPLE_W;

	// scaling of the Q1.15 table to AMP_BITS
	localparam int SH_UP = (AMP_BITS > 16) ? AMP_BITS - 16 : 0;
	localparam int SH_DN = (AMP_BITS < 16) ? 16 - AMP_BITS : 1;

	// request codes
	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_SAMPLE = 2'd2;

	// channel numbering, noise is the last one
	localparam int         TONE_CHANNELS = 3;
	localparam logic [1:0] NOISE_CH      = 2'd3;

	// noise shift register reload and fixed noise rates
	localparam logic [15:0] NOISE_SEED   = 16'h8000;
	localparam logic [10:0] NOISE_RATE_0 = 11'h010;
	localparam logic [10:0] NOISE_RATE_1 = 11'h020;
	localparam logic [10:0] NOISE_RATE_2 = 11'h040;

	// saturation bounds of the mixed sample
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(131071);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(131072);

	// 2 dB steps, Q1.15
	localparam logic [15:0] AMP_Q15 [16] = '{
		16'd32767, 16'd26029, 16'd20675, 16'd16423,
		16'd13045, 16'd10362, 16'd8231,  16'd6538,
		16'd5193,  16'd4125,  16'd3277,  16'd2603,
		16'd2068,  16'd1642,  16'd1305,  16'd0
	};

	typedef logic [AMP_BITS-1:0] amp_t;

	// input word
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} req_t;

	// attenuation code to amplitude at AMP_BITS, round half up when narrowing
	function automatic amp_t amp_of(input logic [3:0] att);
		logic [31:0] a;
		a = {16'd0, AMP_Q15[att]};
		if (AMP_BITS >= 16) begin
			a = a << SH_UP;
		end else begin
			a = (a + (32'd1 << (SH_DN - 1))) >> SH_DN;
		end
		return a[AMP_BITS-1:0];
	endfunction

endpackage

/* hdl/psg_if.sv */
// request and sample stream interfaces of the tone and noise generator
interface psg_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface psg_rsp_if;
	logic                      valid;
	logic                      ready;
	logic signed [17:0]        sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* hdl/psg_tone_noise_generator.sv */
// three-tone, one-noise sound generator: register writes, ticks and mixed samples
//
// One request word is taken every clock cycle while req.ready is high. A word is
// first held in an input register; when it leaves it, a register write updates
// one channel, a tick updates all four channels in parallel logic and a sample
// request registers the saturated mix in the result register that drives rsp. req.ready only
// drops while a sample request sits in the input register behind a sample word
// that rsp has not yet taken; writes and ticks never wait on rsp.
module psg_tone_noise_generator (
	input logic       clk,
	input logic       arst_n,
	psg_req_if.sink   req,
	psg_rsp_if.source rsp
);

	// input register
	logic           valid_s1;
	psg_pkg::req_t  word_s1;
	logic           go_s1;

	// channel state
	logic [1:0]         latched_channel_q, latched_channel_d;
	logic               latched_is_volume_q, latched_is_volume_d;
	logic [9:0]         tone_period_q [psg_pkg::TONE_CHANNELS];
	logic [9:0]         tone_period_d [psg_pkg::TONE_CHANNELS];
	logic signed [10:0] tone_count_q [psg_pkg::TONE_CHANNELS];
	logic signed [10:0] tone_count_d [psg_pkg::TONE_CHANNELS];
	logic               tone_positive_q [psg_pkg::TONE_CHANNELS];
	logic               tone_positive_d [psg_pkg::TONE_CHANNELS];
	logic [3:0]         attenuation_q [4];
	logic [3:0]         attenuation_d [4];
	logic [2:0]         noise_control_q, noise_control_d;
	logic signed [10:0] noise_count_q, noise_count_d;
	logic [15:0]        noise_shift_q, noise_shift_d;
	logic               noise_positive_q, noise_positive_d;

	// result register
	logic                             rsp_valid_q;
	logic signed [psg_pkg::SAMPLE_W-1:0] sample_q;

	logic signed [10:0]             cnt_dec;
	logic signed [10:0]             noise_dec;
	logic                           fb;
	logic [10:0]                    noise_reload;
	logic signed [psg_pkg::SUM_W-1:0] sum;
	logic signed [psg_pkg::SUM_W-1:0] term;
	psg_pkg::amp_t                  amp;
	logic signed [psg_pkg::SUM_W-1:0] mix;

	// a sample request waits only for a free result register
	assign go_s1 = valid_s1 && !(word_s1.func == psg_pkg::FUNC_SAMPLE
		&& rsp_valid_q && !rsp.ready);
	assign req.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			word_s1.func      <= req.func;
			word_s1.data_byte <= req.data_byte;
		end
	end

	// next channel state from a write or a tick
	always_comb begin
		latched_channel_d   = latched_channel_q;
		latched_is_volume_d = latched_is_volume_q;
		tone_period_d       = tone_period_q;
		tone_count_d        = tone_count_q;
		tone_positive_d     = tone_positive_q;
		attenuation_d       = attenuation_q;
		noise_control_d     = noise_control_q;
		noise_count_d       = noise_count_q;
		noise_shift_d       = noise_shift_q;
		noise_positive_d    = noise_positive_q;
		cnt_dec             = '0;
		noise_dec           = noise_count_q - 11'sd1;
		fb                  = 1'b0;
		noise_reload        = psg_pkg::NOISE_RATE_0;

		if (go_s1 && word_s1.func == psg_pkg::FUNC_WRITE) begin
			if (word_s1.data_byte[7]) begin
				// latch byte
				latched_channel_d   = word_s1.data_byte[6:5];
				latched_is_volume_d = word_s1.data_byte[4];
				if (word_s1.data_byte[4]) begin
					attenuation_d[word_s1.data_byte[6:5]] = word_s1.data_byte[3:0];
				end else if (word_s1.data_byte[6:5] != psg_pkg::NOISE_CH) begin
					tone_period_d[word_s1.data_byte[6:5]][3:0] = word_s1.data_byte[3:0];
				end else begin
					noise_control_d = word_s1.data_byte[2:0];
					noise_shift_d   = psg_pkg::NOISE_SEED;
				end
			end else begin
				// data byte to the latched register
				if (latched_is_volume_q) begin
					attenuation_d[latched_channel_q] = word_s1.data_byte[3:0];
				end else if (latched_channel_q != psg_pkg::NOISE_CH) begin
					tone_period_d[latched_channel_q][9:4] = word_s1.data_byte[5:0];
				end else begin
					noise_control_d = word_s1.data_byte[2:0];
					noise_shift_d   = psg_pkg::NOISE_SEED;
				end
			end
		end

		if (go_s1 && word_s1.func == psg_pkg::FUNC_TICK) begin
			// tone counters, a zero period reloads with one
			for (int ch = 0; ch < psg_pkg::TONE_CHANNELS; ch++) begin
				cnt_dec = tone_count_q[ch] - 11'sd1;
				tone_count_d[ch] = cnt_dec;
				if (cnt_dec <= 11'sd0) begin
					tone_positive_d[ch] = !tone_positive_q[ch];
					tone_count_d[ch] = (tone_period_q[ch] == 10'd0) ? 11'sd1
						: signed'({1'b0, tone_period_q[ch]});
				end
			end
			// noise counter and shift register
			noise_count_d = noise_dec;
			if (noise_dec <= 11'sd0) begin
				fb = noise_control_q[2] ? (noise_shift_q[0] ^ noise_shift_q[3])
					: noise_shift_q[0];
				noise_shift_d    = {fb, noise_shift_q[15:1]};
				noise_positive_d = noise_shift_q[1];
				case (noise_control_q[1:0])
					2'd0: noise_reload = psg_pkg::NOISE_RATE_0;
					2'd1: noise_reload = psg_pkg::NOISE_RATE_1;
					2'd2: noise_reload = psg_pkg::NOISE_RATE_2;
					default: begin
						noise_reload = (tone_period_q[2] == 10'd0) ? 11'd1
							: {1'b0, tone_period_q[2]};
					end
				endcase
				noise_count_d = signed'(noise_reload);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_channel_q   <= '0;
			latched_is_volume_q <= 1'b0;
			for (int ch = 0; ch < psg_pkg::TONE_CHANNELS; ch++) begin
				tone_period_q[ch]   <= '0;
				tone_count_q[ch]    <= '0;
				tone_positive_q[ch] <= 1'b1;
			end
			for (int ch = 0; ch < 4; ch++) begin
				attenuation_q[ch] <= 4'hF;
			end
			noise_control_q  <= '0;
			noise_count_q    <= '0;
			noise_shift_q    <= psg_pkg::NOISE_SEED;
			noise_positive_q <= 1'b1;
		end else begin
			latched_channel_q   <= latched_channel_d;
			latched_is_volume_q <= latched_is_volume_d;
			tone_period_q       <= tone_period_d;
			tone_count_q        <= tone_count_d;
			tone_positive_q     <= tone_positive_d;
			attenuation_q       <= attenuation_d;
			noise_control_q     <= noise_control_d;
			noise_count_q       <= noise_count_d;
			noise_shift_q       <= noise_shift_d;
			noise_positive_q    <= noise_positive_d;
		end
	end

	// mix of the four channels, silent tones with a zero period
	always_comb begin
		sum = '0;
		for (int ch = 0; ch < 4; ch++) begin
			amp  = psg_pkg::amp_of(attenuation_q[ch]);
			term = signed'({{(psg_pkg::SUM_W - psg_pkg::AMP_BITS){1'b0}}, amp});
			if (ch < psg_pkg::TONE_CHANNELS) begin
				if (tone_period_q[ch] == 10'd0) begin
					term = '0;
				end else if (!tone_positive_q[ch]) begin
					term = -term;
				end
			end else if (!noise_positive_q) begin
				term = -term;
			end
			sum = sum + term;
		end
		if (sum > psg_pkg::SUM_MAX) begin
			mix = psg_pkg::SUM_MAX;
		end else if (sum < psg_pkg::SUM_MIN) begin
			mix = psg_pkg::SUM_MIN;
		end else begin
			mix = sum;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go_s1 && word_s1.func == psg_pkg::FUNC_SAMPLE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && word_s1.func == psg_pkg::FUNC_SAMPLE) begin
			sample_q <= mix[psg_pkg::SAMPLE_W-1:0];
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.sample = sample_q;

	// a sample request that leaves the input register shows up as a word
	a_sample_out: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && word_s1.func == psg_pkg::FUNC_SAMPLE |=> rsp_valid_q)
		else $error("sample request lost");

	// the input side stalls only behind a waiting sample word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && rsp_valid_q && !rsp.ready)
		else $error("input stalled without cause");

	// the noise shift register never locks up at zero
	a_noise_live: assert property (@(posedge clk) disable iff (!arst_n)
		noise_shift_q != 16'd0)
		else $error("noise shift register is zero");

	// tone counters stay within the reload range
	a_tone_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(go_s1 && word_s1.func == psg_pkg::FUNC_TICK)
		|-> tone_count_q[0] > 11'sd0 && tone_count_q[1] > 11'sd0
		&& tone_count_q[2] > 11'sd0)
		else $error("tone counter out of range after tick");

endmodule
